[rtl/core/gtlw_pkg.sv]
package gtlw_pkg;

  // Character classes carried on the input channel.
  localparam logic [2:0] KIND_ORDINARY = 3'd0;
  localparam logic [2:0] KIND_SPACE    = 3'd1;
  localparam logic [2:0] KIND_CR       = 3'd2;
  localparam logic [2:0] KIND_LF       = 3'd3;
  localparam logic [2:0] KIND_EOT      = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_SCALE     = 1'b0;
  localparam logic CFG_MAX_WIDTH = 1'b1;

  localparam logic [7:0]  SCALE_RESET     = 8'd1;
  localparam logic [15:0] MAX_WIDTH_RESET = 16'd320;
  localparam logic [15:0] WIDTH_SAT       = 16'hFFFF;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] glyph_width;
  } gtlw_in_t;

  typedef struct packed {
    logic [15:0] line_start;
    logic [15:0] line_length;
    logic [15:0] line_width;
    logic        end_of_text;
  } gtlw_out_t;

  // Staged character: class plus its already scaled width.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] cw;
  } gtlw_work_t;

endpackage

[rtl/core/gtlw_step.sv]
module gtlw_step #(
  parameter int MAX_TEXT_LENGTH = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  gtlw_pkg::gtlw_work_t item,
  input  logic [15:0]       max_width,
  output logic              res_vld,
  output gtlw_pkg::gtlw_out_t res
);
  import gtlw_pkg::*;

  localparam int IW = $clog2(MAX_TEXT_LENGTH);
  localparam logic [IW:0]   MTL  = (IW + 1)'(MAX_TEXT_LENGTH);
  localparam logic [IW-1:0] LAST = IW'(MAX_TEXT_LENGTH - 1);

  logic [IW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] start_r, start_nxt;
  logic [IW-1:0] space_r, space_nxt;
  logic [15:0]   run_r, run_nxt;
  logic [15:0]   wbs_r, wbs_nxt;
  logic [15:0]   lsw_r, lsw_nxt;

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] v);
    return (v == LAST) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [15:0] idx_diff(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + MTL;
    end
    return 16'(d[IW-1:0]);
  endfunction

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? WIDTH_SAT : s[15:0];
  endfunction

  logic [16:0] fit_sum;
  logic        no_fit;
  logic [15:0] used;
  logic [15:0] rest;

  assign fit_sum = {1'b0, run_r} + {1'b0, item.cw};
  assign no_fit  = fit_sum > {1'b0, max_width};
  assign used    = sat_add(wbs_r, lsw_r);
  assign rest    = (run_r > used) ? run_r - used : '0;

  always_comb begin
    pos_nxt   = idx_next(pos_r);
    start_nxt = start_r;
    space_nxt = space_r;
    run_nxt   = run_r;
    wbs_nxt   = wbs_r;
    lsw_nxt   = lsw_r;
    res_vld   = 1'b0;
    res       = '{line_start:  16'(start_r),
                  line_length: idx_diff(pos_r, start_r),
                  line_width:  run_r,
                  end_of_text: 1'b0};
    unique case (item.kind)
      KIND_EOT: begin
        res_vld         = run_r != '0;
        res.end_of_text = 1'b1;
        pos_nxt   = '0;
        start_nxt = '0;
        space_nxt = '0;
        run_nxt   = '0;
        wbs_nxt   = '0;
        lsw_nxt   = '0;
      end
      KIND_LF: begin
        res_vld = 1'b1;
        if (run_r == '0) begin
          res.line_start  = 16'(pos_r);
          res.line_length = '0;
        end
        start_nxt = idx_next(pos_r);
        space_nxt = '0;
        wbs_nxt   = '0;
        run_nxt   = '0;
      end
      KIND_CR: begin
      end
      KIND_ORDINARY, KIND_SPACE: begin
        if (no_fit) begin
          if (item.kind == KIND_SPACE) begin
            res_vld   = run_r != '0;
            start_nxt = idx_next(pos_r);
            space_nxt = '0;
            wbs_nxt   = '0;
            run_nxt   = '0;
          end else if (space_r > start_r) begin
            res_vld         = wbs_r != '0;
            res.line_length = idx_diff(space_r, start_r);
            res.line_width  = wbs_r;
            start_nxt = idx_next(space_r);
            run_nxt   = sat_add(rest, item.cw);
            space_nxt = '0;
            wbs_nxt   = '0;
          end else begin
            res_vld   = run_r != '0;
            start_nxt = pos_r;
            space_nxt = '0;
            wbs_nxt   = '0;
            run_nxt   = item.cw;
          end
        end else if (item.kind == KIND_SPACE) begin
          if (run_r != '0) begin
            space_nxt = pos_r;
            wbs_nxt   = run_r;
            run_nxt   = sat_add(run_r, item.cw);
            lsw_nxt   = item.cw;
          end else begin
            start_nxt = idx_next(pos_r);
            space_nxt = '0;
            wbs_nxt   = '0;
            run_nxt   = '0;
          end
        end else begin
          run_nxt = sat_add(run_r, item.cw);
        end
      end
      default: begin
        // unused classes: no effect at all
        pos_nxt = pos_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
      space_r <= '0;
      run_r   <= '0;
      wbs_r   <= '0;
      lsw_r   <= '0;
    end else if (adv) begin
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      space_r <= space_nxt;
      run_r   <= run_nxt;
      wbs_r   <= wbs_nxt;
      lsw_r   <= lsw_nxt;
    end
  end

endmodule

[rtl/core/greedy_text_line_wrapper.sv]
// Greedy text line wrapper: accepts one character request per cycle (class plus
// unscaled glyph width) and emits a line request (start index, length in
// characters, pixel width, end-of-text flag) whenever a line is broken at the
// last space, cut mid-word, ended by a line feed or flushed by end of text.
// The input stage registers the character and the output register the line
// request. Throughput is one character per cycle unless the output stalls, set
// by the update of the line state (running width, line start, last space). A
// request is taken while a finished line waits, if the staged one can move on.
// Write scale and max_width only while the block is idle.
module greedy_text_line_wrapper #(
  parameter int MAX_TEXT_LENGTH = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gtlw_pkg::gtlw_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gtlw_pkg::gtlw_out_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [15:0]         cfg_wdata
);
  import gtlw_pkg::*;

  // Configuration registers.
  logic [7:0]  scale_r;
  logic [15:0] max_width_r;

  // Input stage: the character with its scaled width.
  logic       stg_vld_r, stg_vld_nxt;
  gtlw_work_t stg_r;

  // Output register.
  logic      out_vld_r, out_vld_nxt;
  gtlw_out_t out_r;

  logic      in_acc;
  logic      adv;
  logic      res_vld;
  gtlw_out_t res;

  // Advance the staged character when the output register can take a line.
  assign adv      = stg_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = stg_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_RESET;
      max_width_r <= MAX_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SCALE:     scale_r     <= cfg_wdata[7:0];
        CFG_MAX_WIDTH: max_width_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    stg_vld_nxt = stg_vld_r;
    if (in_acc) begin
      stg_vld_nxt = 1'b1;
    end else if (adv) begin
      stg_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = res_vld;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Scale on capture: 8 x 8 bits never exceeds 16 bits, so no saturation here.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_r.kind <= in_data.kind;
      stg_r.cw   <= 16'(in_data.glyph_width) * 16'(scale_r);
    end
    if (adv && res_vld) begin
      out_r <= res;
    end
  end

  gtlw_step #(
    .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (stg_r),
    .max_width (max_width_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  // A full output register that is stalled must hold back the input stage.
  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    stg_vld_r && out_vld_r && out_stall |-> in_stall)
    else $error("input stage advanced into a stalled output");

  // An accepted character is staged in the next cycle.
  a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> stg_vld_r)
    else $error("accepted character not staged");

  // A final flush is emitted only for a line with pixels in it.
  a_flush_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.end_of_text || out_data.line_width != 16'd0))
    else $error("end-of-text line with zero width");

  // A new line loaded only while the old one is gone or being taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> $stable(out_r))
    else $error("pending line overwritten");

endmodule
